@@ rtl/swpd_pkg.sv @@
// ----------------------------------------------------------------------------
// swpd_pkg: shared types and constants of the sliding window peak detector
// Beat layouts, window entry, probe and hit groups, register and verdict codes.
// ----------------------------------------------------------------------------
package swpd_pkg;

  localparam int unsigned MaxHalfSpanDef = 31;
  localparam int unsigned MaxResults     = 32;
  localparam int unsigned ResCntW        = $clog2(MaxResults + 1);
  localparam int unsigned SampleW        = 32;
  localparam int unsigned SpanW          = 5;
  localparam int unsigned EndW           = 2;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_SPAN = 2'd0,
    CFG_STRICT    = 2'd1,
    CFG_END_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_NOT_PEAK = 2'd0,
    VERDICT_PEAK     = 2'd1,
    VERDICT_MISSING  = 2'd2
  } verdict_e;

  typedef enum logic [EndW-1:0] {
    END_NOT_PEAK = 2'd0,
    END_USE_DATA = 2'd1,
    END_MISSING  = 2'd2
  } end_mode_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      sample_missing;
    logic                      column_end;
  } in_beat_t;

  typedef struct packed {
    verdict_e verdict;
    logic     last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic                      miss;
  } entry_t;

  typedef struct packed {
    logic signed [SampleW-1:0] cv;
    logic                      strict;
  } probe_t;

  typedef struct packed {
    logic missing;
    logic beaten;
  } hit_t;

endpackage

@@ rtl/swpd_stream_if.sv @@
// ----------------------------------------------------------------------------
// swpd_stream_if: valid/ready stream channel
// One beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface swpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/swpd_cell.sv @@
// ----------------------------------------------------------------------------
// swpd_cell: one window position of the peak detector chain
// Holds one sample, hands it to the older neighbor on each shift, offers it as
// the center when addressed and judges it against the broadcast center value.
// ----------------------------------------------------------------------------
module swpd_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned IdxW  = 6
) (
  input  logic              clk_i,
  input  logic              shift_i,
  input  swpd_pkg::entry_t  entry_i,
  output swpd_pkg::entry_t  entry_o,
  input  swpd_pkg::probe_t  probe_i,
  input  logic [IdxW-1:0]   center_i,
  input  logic [IdxW-1:0]   lo_i,
  input  logic [IdxW-1:0]   hi_i,
  output swpd_pkg::entry_t  tap_o,
  output swpd_pkg::hit_t    hit_o
);
  import swpd_pkg::*;

  localparam logic [IdxW-1:0] Pos = IdxW'(Index);

  entry_t entry_q;
  logic   is_center;
  logic   in_win;
  logic   greater;
  logic   equal;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o   = entry_q;
  assign is_center = (center_i == Pos);
  assign in_win    = (Pos >= lo_i) && (Pos <= hi_i) && !is_center;
  assign greater   = $signed(entry_q.value) > $signed(probe_i.cv);
  assign equal     = (entry_q.value == probe_i.cv);

  assign tap_o          = is_center ? entry_q : '0;
  assign hit_o.missing  = in_win && entry_q.miss;
  assign hit_o.beaten   = in_win && !entry_q.miss && (greater || (probe_i.strict && equal));

endmodule

@@ rtl/sliding_window_peak_detector.sv @@
// ----------------------------------------------------------------------------
// sliding_window_peak_detector: local maximum verdicts over a sample stream
// Compares each center sample with up to half_span neighbors on each side.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one sample per beat (value, missing flag, column end mark).
//   out_if carries verdicts (not peak, peak, missing) in center order, with
//   last_of_run set on the final verdict of a column.
//   cfg_we_i/cfg_idx_i/cfg_data_i write half_span, strict_mode, end_mode;
//   write them only while the block is idle.
// Timing:
//   After the accepting edge the block takes each verdict through center
//   select, then compare across the cell chain, and ends the item with a
//   closing select step.
//   The cell chain is the one shared compare unit; in_if.ready is high only
//   while no item is in work.
// Reset: registers return to half_span 1, strict_mode 1, end_mode 0, with an
//   empty column; window contents are not cleared.
// Stall: a held verdict waits in the output register; the compare step waits
//   for it to drain, and nothing is dropped.
// ----------------------------------------------------------------------------
module sliding_window_peak_detector #(
  parameter int unsigned MAX_HALF_SPAN = swpd_pkg::MaxHalfSpanDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swpd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [swpd_pkg::CfgDataW-1:0]  cfg_data_i,
  swpd_stream_if.sink                    in_if,
  swpd_stream_if.source                  out_if
);
  import swpd_pkg::*;

  localparam int unsigned Depth = 2 * MAX_HALF_SPAN + 1;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEL  = 3'b010,
    ST_CMP  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      cc_q, cc_d;
  logic [CntW-1:0]      pend_q, pend_d;
  logic [IdxW-1:0]      h_q, h_d;
  logic                 col_end_q, col_end_d;
  logic [ResCntW-1:0]   n_q, n_d;
  logic [IdxW-1:0]      a_q, lo_q, hi_q;
  logic                 trunc_q;
  entry_t               cv_q;
  logic                 sel_load;

  logic [SpanW-1:0]     half_span_q;
  logic                 strict_q;
  logic [EndW-1:0]      end_mode_q;

  logic                 out_valid_q;
  out_beat_t            out_q, out_d;
  logic                 out_load;

  logic                 accept;
  logic [IdxW-1:0]      h_eff;
  logic [CntW-1:0]      h_ext;
  logic                 more;
  logic [CntW-1:0]      a_sel, left_raw, left, right, lo_sel, hi_sel;
  logic                 trunc_sel;
  logic [IdxW-1:0]      center;

  entry_t               new_entry;
  entry_t               chain [Depth];
  entry_t               taps  [Depth];
  hit_t                 hits  [Depth];
  entry_t               tap_any;
  logic                 missing_any;
  logic                 beaten_any;
  probe_t               probe;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);

  assign h_eff = (int'(half_span_q) > int'(MAX_HALF_SPAN)) ? IdxW'(MAX_HALF_SPAN)
                                                           : IdxW'(half_span_q);
  assign h_ext = CntW'(h_q);

  assign more = (n_q < ResCntW'(MaxResults)) &&
                ((pend_q > h_ext) || (col_end_q && (pend_q != '0)));

  always_comb begin
    a_sel     = pend_q - CntW'(1);
    left_raw  = (cc_q > a_sel) ? (cc_q - a_sel - CntW'(1)) : '0;
    left      = (left_raw > h_ext) ? h_ext : left_raw;
    right     = (a_sel < h_ext) ? a_sel : h_ext;
    trunc_sel = (left < h_ext) || (a_sel < h_ext);
    lo_sel    = a_sel - right;
    hi_sel    = a_sel + left;
  end

  assign center = (state_q == ST_SEL) ? IdxW'(a_sel) : a_q;

  assign new_entry.value = in_if.payload.sample;
  assign new_entry.miss  = in_if.payload.sample_missing;
  assign probe.cv        = cv_q.value;
  assign probe.strict    = strict_q;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    swpd_cell #(
      .Index (i),
      .IdxW  (IdxW)
    ) u_cell (
      .clk_i    (clk_i),
      .shift_i  (accept),
      .entry_i  ((i == 0) ? new_entry : chain[(i == 0) ? 0 : i - 1]),
      .entry_o  (chain[i]),
      .probe_i  (probe),
      .center_i (center),
      .lo_i     (lo_q),
      .hi_i     (hi_q),
      .tap_o    (taps[i]),
      .hit_o    (hits[i])
    );
  end

  always_comb begin
    tap_any     = '0;
    missing_any = 1'b0;
    beaten_any  = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      tap_any     = tap_any | taps[i];
      missing_any = missing_any | hits[i].missing;
      beaten_any  = beaten_any | hits[i].beaten;
    end
  end

  always_comb begin
    out_d.last_of_run = col_end_q && (pend_q == CntW'(1));
    if (cv_q.miss || missing_any) begin
      out_d.verdict = VERDICT_MISSING;
    end else if (trunc_q && (end_mode_q == END_NOT_PEAK)) begin
      out_d.verdict = VERDICT_NOT_PEAK;
    end else if (trunc_q && (end_mode_q == END_MISSING)) begin
      out_d.verdict = VERDICT_MISSING;
    end else if (beaten_any) begin
      out_d.verdict = VERDICT_NOT_PEAK;
    end else begin
      out_d.verdict = VERDICT_PEAK;
    end
  end

  always_comb begin
    state_d   = state_q;
    cc_d      = cc_q;
    pend_d    = pend_q;
    h_d       = h_q;
    col_end_d = col_end_q;
    n_d       = n_q;
    sel_load  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cc_d      = (cc_q == CntW'(Depth)) ? cc_q : cc_q + CntW'(1);
          pend_d    = (pend_q == CntW'(Depth)) ? pend_q : pend_q + CntW'(1);
          h_d       = h_eff;
          col_end_d = in_if.payload.column_end;
          n_d       = '0;
          state_d   = ST_SEL;
        end
      end
      ST_SEL: begin
        if (more) begin
          sel_load = 1'b1;
          state_d  = ST_CMP;
        end else begin
          if (col_end_q) begin
            cc_d   = '0;
            pend_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_CMP: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          pend_d   = pend_q - CntW'(1);
          n_d      = n_q + ResCntW'(1);
          state_d  = ST_SEL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cc_q        <= '0;
      pend_q      <= '0;
      h_q         <= '0;
      col_end_q   <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cc_q      <= cc_d;
      pend_q    <= pend_d;
      h_q       <= h_d;
      col_end_q <= col_end_d;
      n_q       <= n_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_load) begin
      a_q     <= IdxW'(a_sel);
      lo_q    <= IdxW'(lo_sel);
      hi_q    <= IdxW'(hi_sel);
      trunc_q <= trunc_sel;
      cv_q    <= tap_any;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_span_q <= SpanW'(1);
      strict_q    <= 1'b1;
      end_mode_q  <= END_NOT_PEAK;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_SPAN: half_span_q <= cfg_data_i[SpanW-1:0];
        CFG_STRICT:    strict_q    <= cfg_data_i[0];
        CFG_END_MODE:  end_mode_q  <= cfg_data_i[EndW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

endmodule
